FILE: hdl/assert_macros.svh
// Assertion macros shared by the blit RTL.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/acbb_pkg.sv
// Package for the aligned, clipped bitmap blit: field widths,
// register indexes and alignment codes. No dependencies.
package acbb_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int POS_W    = 12;  // rect_left, rect_top
  localparam int SIZE_W   = 13;  // rectangle and bitmap sizes
  localparam int ALIGN_W  = 4;
  localparam int LAYER_W  = 8;
  localparam int COLOR_W  = 16;
  localparam int OUT_W    = 13;  // write_x, write_y
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT     = 3'd0,
    REG_RECT_TOP      = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_BITMAP_WIDTH  = 3'd4,
    REG_BITMAP_HEIGHT = 3'd5,
    REG_ALIGN_MODE    = 3'd6,
    REG_Z_ORDER       = 3'd7
  } cfg_reg_t;

  // Per-axis alignment codes; the fourth code places at offset zero
  localparam logic [1:0] ALIGN_CENTER = 2'd0;
  localparam logic [1:0] ALIGN_NEAR   = 2'd1;
  localparam logic [1:0] ALIGN_FAR    = 2'd2;

  localparam logic [ALIGN_W-1:0] ALIGN_RESET = {ALIGN_NEAR, ALIGN_NEAR};

endpackage

FILE: hdl/aligned_clipped_bitmap_blit.sv
// Aligned, clipped RGB565 bitmap blit: two-stage pixel pipeline.
// Depends on acbb_pkg and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_pixel_color, in_first_pixel
//   out      output     out_valid/out_stall  out_write_x/_y/_color/_layer
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per clock sustained while out_stall is low; a transferred pixel is registered in stage 1, then stage 2.
// Stage 1 holds the pixel and its bitmap position, stage 2 the clipped write.
// Alignment offsets are registered from the configuration registers that a cfg write updates.
// Reset (rst_n low, synchronous) restores register defaults and zero counters.
// out_stall backs up through both stages to in_stall; dropped pixels use no
// output slot.
`include "assert_macros.svh"

module aligned_clipped_bitmap_blit
  import acbb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COLOR_W-1:0]    in_pixel_color,
  input  logic                  in_first_pixel,
  // write output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_write_x,
  output logic [OUT_W-1:0]      out_write_y,
  output logic [COLOR_W-1:0]    out_write_color,
  output logic [LAYER_W-1:0]    out_write_layer,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_W   = COORD_BITS + 1;
  localparam int DIM_MAX = 1 << COORD_BITS;
  localparam int CMP_W   = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;
  localparam int SUM_W   = (COORD_BITS + 2 > OUT_W) ? COORD_BITS + 2 : OUT_W;

  // Clamp a rectangle size to at most DIM_MAX (zero stays zero)
  function automatic logic [DIM_W-1:0] clamp_rect(input logic [SIZE_W-1:0] v);
    logic [CMP_W-1:0] ve;
    logic [DIM_W-1:0] res;
    ve = CMP_W'(v);
    if (ve > CMP_W'(DIM_MAX)) res = DIM_W'(DIM_MAX);
    else                      res = DIM_W'(ve);
    return res;
  endfunction

  // Clamp a bitmap size to 1..DIM_MAX
  function automatic logic [DIM_W-1:0] clamp_bitmap(input logic [SIZE_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = clamp_rect(v);
    if (res == '0) res = DIM_W'(1);
    return res;
  endfunction

  // Offset of the bitmap inside the rectangle along one axis
  function automatic logic [COORD_BITS-1:0] axis_offset(input logic [1:0]       code,
                                                         input logic [DIM_W-1:0] rsize,
                                                         input logic [DIM_W-1:0] bsize);
    logic [DIM_W-1:0]      diff;
    logic [COORD_BITS-1:0] res;
    diff = rsize - bsize;
    res  = '0;
    if (rsize > bsize) begin
      case (code)
        ALIGN_CENTER: res = COORD_BITS'(diff >> 1);
        ALIGN_FAR:    res = COORD_BITS'(diff);
        default:      res = '0;
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [POS_W-1:0]   rect_left_r, rect_top_r;
  logic [SIZE_W-1:0]  rect_width_r, rect_height_r;
  logic [SIZE_W-1:0]  bitmap_width_r, bitmap_height_r;
  logic [ALIGN_W-1:0] align_mode_r;
  logic [LAYER_W-1:0] z_order_r;
  cfg_reg_t           cfg_sel;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_reg_t'(cfg_index);

  // Decode the register index on each cfg transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r     <= '0;
      rect_top_r      <= '0;
      rect_width_r    <= SIZE_W'(1);
      rect_height_r   <= SIZE_W'(1);
      bitmap_width_r  <= SIZE_W'(1);
      bitmap_height_r <= SIZE_W'(1);
      align_mode_r    <= ALIGN_RESET;
      z_order_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_sel)
        REG_RECT_LEFT:     rect_left_r     <= cfg_data[POS_W-1:0];
        REG_RECT_TOP:      rect_top_r      <= cfg_data[POS_W-1:0];
        REG_RECT_WIDTH:    rect_width_r    <= cfg_data[SIZE_W-1:0];
        REG_RECT_HEIGHT:   rect_height_r   <= cfg_data[SIZE_W-1:0];
        REG_BITMAP_WIDTH:  bitmap_width_r  <= cfg_data[SIZE_W-1:0];
        REG_BITMAP_HEIGHT: bitmap_height_r <= cfg_data[SIZE_W-1:0];
        REG_ALIGN_MODE:    align_mode_r    <= cfg_data[ALIGN_W-1:0];
        REG_Z_ORDER:       z_order_r       <= cfg_data[LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Derived geometry: clamped sizes and screen base of the bitmap
  logic [DIM_W-1:0] rect_w_nxt, rect_h_nxt, bmp_w, bmp_h;
  logic [DIM_W-1:0] rect_w_r, rect_h_r;
  logic [SUM_W-1:0] base_x_nxt, base_y_nxt, base_x_r, base_y_r;

  assign rect_w_nxt = clamp_rect(rect_width_r);
  assign rect_h_nxt = clamp_rect(rect_height_r);
  assign bmp_w      = clamp_bitmap(bitmap_width_r);
  assign bmp_h      = clamp_bitmap(bitmap_height_r);
  assign base_x_nxt = SUM_W'(rect_left_r)
                    + SUM_W'(axis_offset(align_mode_r[1:0], rect_w_nxt, bmp_w));
  assign base_y_nxt = SUM_W'(rect_top_r)
                    + SUM_W'(axis_offset(align_mode_r[3:2], rect_h_nxt, bmp_h));

  // Refresh the derived geometry every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_w_r <= DIM_W'(1);
      rect_h_r <= DIM_W'(1);
      base_x_r <= '0;
      base_y_r <= '0;
    end else begin
      rect_w_r <= rect_w_nxt;
      rect_h_r <= rect_h_nxt;
      base_x_r <= base_x_nxt;
      base_y_r <= base_y_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  logic in_xfer, s2_adv;
  logic s1_v_r, out_valid_r;

  assign s2_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_v_r && !s2_adv;
  assign in_xfer  = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Stage 1: bitmap position counters and input register
  logic [COORD_BITS-1:0] col_cnt_r, row_cnt_r, col_cnt_nxt, row_cnt_nxt;
  logic [COORD_BITS-1:0] cur_col, cur_row;
  logic [COORD_BITS-1:0] s1_col_r, s1_row_r;
  logic [COLOR_W-1:0]    s1_color_r;
  logic                  col_wrap, row_wrap;

  assign cur_col  = in_first_pixel ? '0 : col_cnt_r;
  assign cur_row  = in_first_pixel ? '0 : row_cnt_r;
  assign col_wrap = ({1'b0, cur_col} + DIM_W'(1)) >= bmp_w;
  assign row_wrap = ({1'b0, cur_row} + DIM_W'(1)) >= bmp_h;

  // Advance column, wrap to the next row and past the last row to the start
  always_comb begin
    col_cnt_nxt = cur_col + COORD_BITS'(1);
    row_cnt_nxt = cur_row;
    if (col_wrap) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = row_wrap ? '0 : cur_row + COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
      if (in_xfer) s1_v_r <= 1'b1;
      else if (s2_adv) s1_v_r <= 1'b0;
    end
  end

  // Hold the accepted pixel and its position
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_col_r   <= cur_col;
      s1_row_r   <= cur_row;
      s1_color_r <= in_pixel_color;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: clip against the rectangle and form the screen write
  logic             s1_inside;
  logic [SUM_W-1:0] sum_x, sum_y;
  logic [OUT_W-1:0] write_x_r, write_y_r;
  logic [COLOR_W-1:0] write_color_r;
  logic [LAYER_W-1:0] write_layer_r;

  assign s1_inside = ({1'b0, s1_col_r} < rect_w_r) && ({1'b0, s1_row_r} < rect_h_r);
  assign sum_x     = base_x_r + SUM_W'(s1_col_r);
  assign sum_y     = base_y_r + SUM_W'(s1_row_r);

  // Drop clipped pixels; load a write when the output slot frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s1_v_r && s1_inside;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      write_x_r     <= sum_x[OUT_W-1:0];
      write_y_r     <= sum_y[OUT_W-1:0];
      write_color_r <= s1_color_r;
      write_layer_r <= z_order_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_x     = write_x_r;
  assign out_write_y     = write_y_r;
  assign out_write_color = write_color_r;
  assign out_write_layer = write_layer_r;

  // ---------------------------------------------------------------------------
  // Checks
  `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, in_stall, s1_v_r && out_valid_r && out_stall)
  `ASSERT_NEXT(a_stage1_holds, clk, rst_n, s1_v_r && in_stall, s1_v_r)
  `ASSERT_NEXT(a_first_restarts, clk, rst_n, in_xfer && in_first_pixel, s1_v_r && s1_col_r == '0 && s1_row_r == '0)
  `ASSERT_IMPLIES(a_out_from_stage1, clk, rst_n, $rose(out_valid_r), $past(s1_v_r))

endmodule
